@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a condition at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

@@ sv/kct_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyed count table package
// Field widths, opcodes, status codes and the arithmetic unit request type.
// ----------------------------------------------------------------------------
package kct_pkg;

	localparam int OPC_W   = 3;
	localparam int KEY_W   = 16;
	localparam int AMT_W   = 32;
	localparam int SIDX_W  = 6;
	localparam int STAT_W  = 3;
	localparam int SLOT_W  = 6;
	localparam int USED_W  = 6;
	localparam int DATA_W  = 64;
	localparam int ENTRY_W = KEY_W + AMT_W;
	// Two guard bits keep the sign of any difference of 33-bit sums.
	localparam int ALU_W   = AMT_W + 2;

	localparam logic [AMT_W-1:0] LIMIT_RESET = 32'hFFFF_FFFF;

	// Register index, taken from paddr[2]
	localparam logic REG_COUNT_LIMIT = 1'b0;

	typedef enum logic [OPC_W-1:0] {
		OP_ADD         = 3'd0,
		OP_REMOVE      = 3'd1,
		OP_FIND_KEY    = 3'd2,
		OP_READ_SLOT   = 3'd3,
		OP_FIND_AMOUNT = 3'd4
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE       = 3'd0,
		ST_NEW        = 3'd1,
		ST_REMOVED    = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_OVERFLOW   = 3'd4,
		ST_UNDERFLOW  = 3'd5,
		ST_BAD_AMOUNT = 3'd6
	} status_t;

	// One request to the shared add/subtract unit
	typedef struct packed {
		logic             en;
		logic             sub;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

endpackage

@@ sv/kct_alu.sv @@
// ----------------------------------------------------------------------------
// Keyed count table arithmetic unit
// Shared add/subtract with a registered result; sign bit flags a borrow.
// ----------------------------------------------------------------------------
module kct_alu (
	input  logic                          clk,
	input  kct_pkg::alu_req_t             req,
	output logic [kct_pkg::ALU_W-1:0]     res_q
);

	logic [kct_pkg::ALU_W-1:0] b_eff;
	logic [kct_pkg::ALU_W-1:0] sum;

	// Subtract as a + ~b + 1
	assign b_eff = req.sub ? ~req.b : req.b;
	assign sum   = req.a + b_eff + kct_pkg::ALU_W'(req.sub);

	always_ff @(posedge clk) begin
		if (req.en) begin
			res_q <= sum;
		end
	end

endmodule

@@ sv/keyed_count_table_core.sv @@
// ----------------------------------------------------------------------------
// Keyed count table core
// Table of signed 16-bit keys with unsigned 32-bit counts, stream in and out.
// ----------------------------------------------------------------------------
// One command word at a time: s_tready is high only while the sequencer is
// idle, and a finished result may still sit in the output register while the
// next word is taken. Live entries sit in slots 1..entries_used in the order
// they were added; a remove that reaches exactly zero deletes the entry and
// moves the later entries down one slot. Every key operation walks the table
// through a single-port-read memory, one entry per cycle while a find amount
// is not stalled, so its run time follows the fill level and the slot where
// the key sits: a search stops at a hit and a miss walks every live entry.
// Bad amounts and unused opcodes skip the walk; unused opcodes are answered
// with status not found. Find amount walks all live entries and emits one
// word per match (tlast on the final one, or a single not-found word); it
// pauses when a further match finds the output register still full. A zero
// amount for add, remove or find amount is answered with status bad amount.
// count_limit (APB address 0, reset all ones) caps any count and may only be
// written while no command is in flight. The table memory needs no clearing
// after reset: only slots below entries_used are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_count_table_core #(
	parameter int SLOTS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// command stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// opcode[2:0], key[18:3], amount[50:19], slot_index[56:51], zero[63:57]
	input  logic [kct_pkg::DATA_W-1:0]   s_tdata,
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[2:0], slot[8:3], entry_key[24:9], entry_amount[56:25],
	// entries_used[62:57], zero[63]
	output logic [kct_pkg::DATA_W-1:0]   m_tdata,
	output logic                         m_tlast
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int UW = $clog2(SLOTS + 1);
	localparam int CW = (UW > kct_pkg::SIDX_W) ? UW : kct_pkg::SIDX_W;

	localparam int KW = kct_pkg::KEY_W;
	localparam int MW = kct_pkg::AMT_W;
	localparam int SW = kct_pkg::SLOT_W;
	localparam int XW = kct_pkg::ALU_W;

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_SCAN      = 10'b00_0000_0010,
		S_SLOT_RD   = 10'b00_0000_0100,
		S_SLOT_WAIT = 10'b00_0000_1000,
		S_ADD_CHK   = 10'b00_0001_0000,
		S_ADD_FIN   = 10'b00_0010_0000,
		S_NEW_CHK   = 10'b00_0100_0000,
		S_REM_CHK   = 10'b00_1000_0000,
		S_SHIFT     = 10'b01_0000_0000,
		S_RESP      = 10'b10_0000_0000
	} state_t;

	// ------------------------------------------------------------------------
	// Input word fields
	// ------------------------------------------------------------------------
	kct_pkg::opcode_t          in_op;
	logic [KW-1:0]             in_key;
	logic [MW-1:0]             in_amt;
	logic [kct_pkg::SIDX_W-1:0] in_sidx;
	logic                      accept;

	assign in_op   = kct_pkg::opcode_t'(s_tdata[2:0]);
	assign in_key  = s_tdata[18:3];
	assign in_amt  = s_tdata[50:19];
	assign in_sidx = s_tdata[56:51];

	// ------------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------------
	state_t                    state_q, state_d;
	logic [MW-1:0]             limit_q;
	logic [UW-1:0]             used_q, used_d;
	logic [UW-1:0]             idx_q, idx_d;     // next entry to read
	logic                      cv_q, cv_d;       // rd_q holds entry cidx_q
	logic [UW-1:0]             cidx_q, cidx_d;
	logic                      pend_v_q, pend_v_d;
	logic                      out_v_q;

	kct_pkg::opcode_t          op_q;
	logic [KW-1:0]             key_q;
	logic [MW-1:0]             amt_q;
	logic [kct_pkg::SIDX_W-1:0] sidx_q;
	logic [AW-1:0]             hit_q, hit_d;
	logic [KW-1:0]             hkey_q, hkey_d;
	logic [MW-1:0]             hcnt_q, hcnt_d;
	logic [MW-1:0]             sum_q, sum_d;
	logic [SW-1:0]             pend_slot_q, pend_slot_d;
	logic [KW-1:0]             pend_key_q, pend_key_d;

	kct_pkg::status_t          r_status_q, r_status_d;
	logic [SW-1:0]             r_slot_q, r_slot_d;
	logic [KW-1:0]             r_key_q, r_key_d;
	logic [MW-1:0]             r_amt_q, r_amt_d;

	kct_pkg::status_t          o_status_q, o_status_d;
	logic [SW-1:0]             o_slot_q, o_slot_d;
	logic [KW-1:0]             o_key_q, o_key_d;
	logic [MW-1:0]             o_amt_q, o_amt_d;
	logic [kct_pkg::USED_W-1:0] o_used_q;
	logic                      o_last_q, o_last_d;
	logic                      out_ld;

	// ------------------------------------------------------------------------
	// Table memory: entry = {count, key}
	// ------------------------------------------------------------------------
	logic [kct_pkg::ENTRY_W-1:0] mem_q [SLOTS];
	logic [kct_pkg::ENTRY_W-1:0] rd_q;
	logic                        rd_en, wr_en;
	logic [AW-1:0]               rd_addr, wr_addr;
	logic [kct_pkg::ENTRY_W-1:0] wr_data;
	logic [KW-1:0]               rd_key;
	logic [MW-1:0]               rd_cnt;

	assign rd_key = rd_q[KW-1:0];
	assign rd_cnt = rd_q[kct_pkg::ENTRY_W-1:KW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// ------------------------------------------------------------------------
	// Shared add/subtract unit
	// ------------------------------------------------------------------------
	kct_pkg::alu_req_t alu_req;
	logic [XW-1:0]     alu_q;
	logic              alu_neg;

	kct_alu u_alu (
		.clk   (clk),
		.req   (alu_req),
		.res_q (alu_q)
	);

	assign alu_neg = alu_q[XW-1];

	// ------------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------------
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == kct_pkg::REG_COUNT_LIMIT);
	assign prdata = (paddr[2] == kct_pkg::REG_COUNT_LIMIT) ? limit_q : '0;

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	logic out_free, scan_more, scan_end, key_hit, amt_hit, stall, bad_amt;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_v_q || m_tready;
	assign scan_more = (idx_q < used_q);
	assign scan_end  = !cv_q && !scan_more;
	assign key_hit   = cv_q && (rd_key == key_q);
	assign amt_hit   = cv_q && (rd_cnt == amt_q);
	assign bad_amt   = ((in_op == kct_pkg::OP_ADD) || (in_op == kct_pkg::OP_REMOVE) ||
	                    (in_op == kct_pkg::OP_FIND_AMOUNT)) && (in_amt == '0);
	// Hold the walk when a second match arrives and the output is still full
	assign stall     = (op_q == kct_pkg::OP_FIND_AMOUNT) && amt_hit && pend_v_q && !out_free;

	always_comb begin
		state_d     = state_q;
		used_d      = used_q;
		idx_d       = idx_q;
		cv_d        = cv_q;
		cidx_d      = cidx_q;
		pend_v_d    = pend_v_q;
		hit_d       = hit_q;
		hkey_d      = hkey_q;
		hcnt_d      = hcnt_q;
		sum_d       = sum_q;
		pend_slot_d = pend_slot_q;
		pend_key_d  = pend_key_q;
		r_status_d  = r_status_q;
		r_slot_d    = r_slot_q;
		r_key_d     = r_key_q;
		r_amt_d     = r_amt_q;
		o_status_d  = r_status_q;
		o_slot_d    = r_slot_q;
		o_key_d     = r_key_q;
		o_amt_d     = r_amt_q;
		o_last_d    = 1'b1;
		out_ld      = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = idx_q[AW-1:0];
		wr_en       = 1'b0;
		wr_addr     = hit_q;
		wr_data     = '0;
		alu_req     = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					idx_d    = '0;
					cv_d     = 1'b0;
					pend_v_d = 1'b0;
					r_slot_d = '0;
					r_key_d  = '0;
					r_amt_d  = '0;
					if (bad_amt) begin
						r_status_d = kct_pkg::ST_BAD_AMOUNT;
						state_d    = S_RESP;
					end else begin
						case (in_op)
							kct_pkg::OP_ADD, kct_pkg::OP_REMOVE,
							kct_pkg::OP_FIND_KEY, kct_pkg::OP_FIND_AMOUNT: begin
								state_d = S_SCAN;
							end
							kct_pkg::OP_READ_SLOT: begin
								state_d = S_SLOT_RD;
							end
							default: begin
								r_status_d = kct_pkg::ST_NOT_FOUND;
								state_d    = S_RESP;
							end
						endcase
					end
				end
			end

			S_SLOT_RD: begin
				if ((sidx_q != '0) && (CW'(sidx_q) <= CW'(used_q))) begin
					rd_en   = 1'b1;
					rd_addr = AW'(sidx_q - kct_pkg::SIDX_W'(1));
					state_d = S_SLOT_WAIT;
				end else begin
					r_status_d = kct_pkg::ST_NOT_FOUND;
					state_d    = S_RESP;
				end
			end

			S_SLOT_WAIT: begin
				r_status_d = kct_pkg::ST_DONE;
				r_slot_d   = SW'(sidx_q);
				r_key_d    = rd_key;
				r_amt_d    = rd_cnt;
				state_d    = S_RESP;
			end

			S_SCAN: begin
				// advance the read walk, one entry per cycle unless stalled
				if (!stall) begin
					rd_en  = scan_more;
					cv_d   = scan_more;
					cidx_d = idx_q;
					if (scan_more) begin
						idx_d = idx_q + UW'(1);
					end
				end
				if (op_q == kct_pkg::OP_FIND_AMOUNT) begin
					if (amt_hit && !stall) begin
						// release the previous match, keep this one back for tlast
						if (pend_v_q) begin
							out_ld     = 1'b1;
							o_status_d = kct_pkg::ST_DONE;
							o_slot_d   = pend_slot_q;
							o_key_d    = pend_key_q;
							o_amt_d    = amt_q;
							o_last_d   = 1'b0;
						end
						pend_v_d    = 1'b1;
						pend_slot_d = SW'(cidx_q) + SW'(1);
						pend_key_d  = rd_key;
					end else if (scan_end) begin
						pend_v_d = 1'b0;
						if (pend_v_q) begin
							r_status_d = kct_pkg::ST_DONE;
							r_slot_d   = pend_slot_q;
							r_key_d    = pend_key_q;
							r_amt_d    = amt_q;
						end else begin
							r_status_d = kct_pkg::ST_NOT_FOUND;
						end
						state_d = S_RESP;
					end
				end else if (key_hit) begin
					hit_d  = cidx_q[AW-1:0];
					hkey_d = rd_key;
					hcnt_d = rd_cnt;
					case (op_q)
						kct_pkg::OP_FIND_KEY: begin
							r_status_d = kct_pkg::ST_DONE;
							r_slot_d   = SW'(cidx_q) + SW'(1);
							r_key_d    = rd_key;
							r_amt_d    = rd_cnt;
							state_d    = S_RESP;
						end
						kct_pkg::OP_ADD: begin
							alu_req.en = 1'b1;
							alu_req.a  = XW'(rd_cnt);
							alu_req.b  = XW'(amt_q);
							state_d    = S_ADD_CHK;
						end
						default: begin
							alu_req.en  = 1'b1;
							alu_req.sub = 1'b1;
							alu_req.a   = XW'(rd_cnt);
							alu_req.b   = XW'(amt_q);
							state_d     = S_REM_CHK;
						end
					endcase
				end else if (scan_end) begin
					if ((op_q == kct_pkg::OP_ADD) && (used_q < UW'(SLOTS))) begin
						// new key: check the amount against the limit
						alu_req.en  = 1'b1;
						alu_req.sub = 1'b1;
						alu_req.a   = XW'(limit_q);
						alu_req.b   = XW'(amt_q);
						state_d     = S_NEW_CHK;
					end else begin
						r_status_d = (op_q == kct_pkg::OP_ADD) ? kct_pkg::ST_OVERFLOW
						                                       : kct_pkg::ST_NOT_FOUND;
						state_d    = S_RESP;
					end
				end
			end

			S_ADD_CHK: begin
				sum_d       = alu_q[MW-1:0];
				alu_req.en  = 1'b1;
				alu_req.sub = 1'b1;
				alu_req.a   = XW'(limit_q);
				alu_req.b   = alu_q;
				state_d     = S_ADD_FIN;
			end

			S_ADD_FIN: begin
				r_slot_d = SW'(hit_q) + SW'(1);
				r_key_d  = hkey_q;
				if (alu_neg) begin
					r_status_d = kct_pkg::ST_OVERFLOW;
					r_amt_d    = hcnt_q;
				end else begin
					wr_en      = 1'b1;
					wr_addr    = hit_q;
					wr_data    = {sum_q, hkey_q};
					r_status_d = kct_pkg::ST_DONE;
					r_amt_d    = sum_q;
				end
				state_d = S_RESP;
			end

			S_NEW_CHK: begin
				if (alu_neg) begin
					r_status_d = kct_pkg::ST_OVERFLOW;
				end else begin
					wr_en      = 1'b1;
					wr_addr    = used_q[AW-1:0];
					wr_data    = {amt_q, key_q};
					used_d     = used_q + UW'(1);
					r_status_d = kct_pkg::ST_NEW;
					r_slot_d   = SW'(used_q) + SW'(1);
					r_key_d    = key_q;
					r_amt_d    = amt_q;
				end
				state_d = S_RESP;
			end

			S_REM_CHK: begin
				r_slot_d = SW'(hit_q) + SW'(1);
				r_key_d  = hkey_q;
				if (alu_neg) begin
					r_status_d = kct_pkg::ST_UNDERFLOW;
					r_amt_d    = hcnt_q;
					state_d    = S_RESP;
				end else if (alu_q == '0) begin
					// delete: pull later entries down one slot
					r_status_d = kct_pkg::ST_REMOVED;
					r_amt_d    = '0;
					idx_d      = UW'(hit_q) + UW'(1);
					cv_d       = 1'b0;
					state_d    = S_SHIFT;
				end else begin
					wr_en      = 1'b1;
					wr_addr    = hit_q;
					wr_data    = {alu_q[MW-1:0], hkey_q};
					r_status_d = kct_pkg::ST_DONE;
					r_amt_d    = alu_q[MW-1:0];
					state_d    = S_RESP;
				end
			end

			S_SHIFT: begin
				rd_en  = scan_more;
				cv_d   = scan_more;
				cidx_d = idx_q;
				if (scan_more) begin
					idx_d = idx_q + UW'(1);
				end
				if (cv_q) begin
					wr_en   = 1'b1;
					wr_addr = AW'(cidx_q - UW'(1));
					wr_data = rd_q;
				end
				if (scan_end) begin
					used_d  = used_q - UW'(1);
					state_d = S_RESP;
				end
			end

			S_RESP: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			limit_q  <= kct_pkg::LIMIT_RESET;
			used_q   <= '0;
			idx_q    <= '0;
			cv_q     <= 1'b0;
			cidx_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			used_q   <= used_d;
			idx_q    <= idx_d;
			cv_q     <= cv_d;
			cidx_q   <= cidx_d;
			pend_v_q <= pend_v_d;
			if (cfg_wr) begin
				limit_q <= pwdata;
			end
			if (out_ld) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_op;
			key_q  <= in_key;
			amt_q  <= in_amt;
			sidx_q <= in_sidx;
		end
		hit_q       <= hit_d;
		hkey_q      <= hkey_d;
		hcnt_q      <= hcnt_d;
		sum_q       <= sum_d;
		pend_slot_q <= pend_slot_d;
		pend_key_q  <= pend_key_d;
		r_status_q  <= r_status_d;
		r_slot_q    <= r_slot_d;
		r_key_q     <= r_key_d;
		r_amt_q     <= r_amt_d;
		if (out_ld) begin
			o_status_q <= o_status_d;
			o_slot_q   <= o_slot_d;
			o_key_q    <= o_key_d;
			o_amt_q    <= o_amt_d;
			o_used_q   <= kct_pkg::USED_W'(used_q);
			o_last_q   <= o_last_d;
		end
	end

	// ------------------------------------------------------------------------
	// Result word
	// ------------------------------------------------------------------------
	assign m_tvalid = out_v_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {1'b0, o_used_q, o_amt_q, o_key_q, o_slot_q, o_status_q};

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`ASSERT_IMPLY(a_used_step, used_q != $past(used_q), (used_q == $past(used_q) + UW'(1)) || (used_q == $past(used_q) - UW'(1)), "entry count moved by more than one")
	`ASSERT_IMPLY(a_wr_state, wr_en, (state_q == S_ADD_FIN) || (state_q == S_NEW_CHK) || (state_q == S_REM_CHK) || (state_q == S_SHIFT), "table written outside an update step")
	`ASSERT_IMPLY(a_pend_scan, pend_v_q, (state_q == S_SCAN) && (op_q == kct_pkg::OP_FIND_AMOUNT), "held match outside an amount search")
	`ASSERT_ALWAYS(a_used_max, used_q <= UW'(SLOTS), "entry count above table size")

endmodule

@@ tb/tb_keyed_count_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed count table core testbench
// Drives command words into the table and checks every result word against a
// behavioral copy of the table held in a scoreboard. The run starts with a
// directed pass over the corner cases, then goes through several count limits
// with random traffic. The sender idles in bursts, and the receiver stalls on
// its own pattern and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_keyed_count_table_core;

	localparam int SLOTS        = 32;
	localparam int LIMIT_CYCLES = 600_000;
	localparam int SETTLE       = 2 * SLOTS + 8;

	// opcodes that the block does not define
	localparam logic [kct_pkg::OPC_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [kct_pkg::OPC_W-1:0] OP_SPARE_LAST  = 3'd7;

	// count_limit register address
	localparam logic [2:0] LIMIT_ADDR = {kct_pkg::REG_COUNT_LIMIT, 2'b00};

	typedef struct {
		logic [kct_pkg::OPC_W-1:0]  op;
		logic [kct_pkg::KEY_W-1:0]  key;
		logic [kct_pkg::AMT_W-1:0]  amount;
		logic [kct_pkg::SIDX_W-1:0] sidx;
	} command_t;

	typedef struct {
		kct_pkg::status_t           status;
		logic [kct_pkg::SLOT_W-1:0] slot;
		logic [kct_pkg::KEY_W-1:0]  key;
		logic [kct_pkg::AMT_W-1:0]  amount;
		logic [kct_pkg::USED_W-1:0] used;
		logic                       last;
	} table_result_t;

	// Scoreboard: keeps its own copy of the table and the words it still owes.
	class count_table_model;
		logic [kct_pkg::KEY_W-1:0] keys[SLOTS];
		logic [kct_pkg::AMT_W-1:0] counts[SLOTS];
		int                        used;
		logic [kct_pkg::AMT_W-1:0] limit;
		int                        errors;
		int                        words_seen;
		table_result_t             due_q[$];

		function new();
			used       = 0;
			limit      = kct_pkg::LIMIT_RESET;
			errors     = 0;
			words_seen = 0;
		endfunction

		// 0-based slot of a key, or used when absent
		function int locate(logic [kct_pkg::KEY_W-1:0] k);
			for (int i = 0; i < used; i++) begin
				if (keys[i] == k)
					return i;
			end
			return used;
		endfunction

		function void queue_result(kct_pkg::status_t st, int slot,
				logic [kct_pkg::KEY_W-1:0] k, logic [kct_pkg::AMT_W-1:0] a, logic lst);
			table_result_t r;
			r.status = st;
			r.slot   = slot[kct_pkg::SLOT_W-1:0];
			r.key    = k;
			r.amount = a;
			r.used   = used[kct_pkg::USED_W-1:0];
			r.last   = lst;
			due_q.push_back(r);
		endfunction

		// Apply one accepted command and queue the words it must produce.
		function void note_command(command_t c);
			int hit;
			int match_total;
			int seen;
			int sidx;
			logic [kct_pkg::KEY_W-1:0] gone;
			sidx = int'(c.sidx);
			if ((c.op == kct_pkg::OP_ADD || c.op == kct_pkg::OP_REMOVE ||
					c.op == kct_pkg::OP_FIND_AMOUNT) && c.amount == '0) begin
				queue_result(kct_pkg::ST_BAD_AMOUNT, 0, '0, '0, 1'b1);
				return;
			end
			case (c.op)
				kct_pkg::OP_ADD: begin
					hit = locate(c.key);
					if (hit < used) begin
						if ({1'b0, counts[hit]} + {1'b0, c.amount} > {1'b0, limit}) begin
							queue_result(kct_pkg::ST_OVERFLOW, hit + 1, keys[hit], counts[hit],
								1'b1);
						end else begin
							counts[hit] += c.amount;
							queue_result(kct_pkg::ST_DONE, hit + 1, keys[hit], counts[hit], 1'b1);
						end
					end else if (used < SLOTS && c.amount <= limit) begin
						keys[used]   = c.key;
						counts[used] = c.amount;
						used++;
						queue_result(kct_pkg::ST_NEW, used, c.key, c.amount, 1'b1);
					end else begin
						queue_result(kct_pkg::ST_OVERFLOW, 0, '0, '0, 1'b1);
					end
				end
				kct_pkg::OP_REMOVE: begin
					hit = locate(c.key);
					if (hit >= used) begin
						queue_result(kct_pkg::ST_NOT_FOUND, 0, '0, '0, 1'b1);
					end else if (counts[hit] > c.amount) begin
						counts[hit] -= c.amount;
						queue_result(kct_pkg::ST_DONE, hit + 1, keys[hit], counts[hit], 1'b1);
					end else if (counts[hit] == c.amount) begin
						gone = keys[hit];
						for (int j = hit; j < used - 1; j++) begin
							keys[j]   = keys[j + 1];
							counts[j] = counts[j + 1];
						end
						used--;
						queue_result(kct_pkg::ST_REMOVED, hit + 1, gone, '0, 1'b1);
					end else begin
						queue_result(kct_pkg::ST_UNDERFLOW, hit + 1, keys[hit], counts[hit],
							1'b1);
					end
				end
				kct_pkg::OP_FIND_KEY: begin
					hit = locate(c.key);
					if (hit < used)
						queue_result(kct_pkg::ST_DONE, hit + 1, keys[hit], counts[hit], 1'b1);
					else
						queue_result(kct_pkg::ST_NOT_FOUND, 0, '0, '0, 1'b1);
				end
				kct_pkg::OP_READ_SLOT: begin
					if (sidx >= 1 && sidx <= used)
						queue_result(kct_pkg::ST_DONE, sidx, keys[sidx - 1], counts[sidx - 1],
							1'b1);
					else
						queue_result(kct_pkg::ST_NOT_FOUND, 0, '0, '0, 1'b1);
				end
				kct_pkg::OP_FIND_AMOUNT: begin
					match_total = 0;
					for (int i = 0; i < used; i++) begin
						if (counts[i] == c.amount)
							match_total++;
					end
					if (match_total == 0) begin
						queue_result(kct_pkg::ST_NOT_FOUND, 0, '0, '0, 1'b1);
					end else begin
						seen = 0;
						for (int i = 0; i < used; i++) begin
							if (counts[i] == c.amount) begin
								seen++;
								queue_result(kct_pkg::ST_DONE, i + 1, keys[i], counts[i],
									seen == match_total);
							end
						end
					end
				end
				default: queue_result(kct_pkg::ST_NOT_FOUND, 0, '0, '0, 1'b1);
			endcase
		endfunction

		task report(string msg);
			$display("[%0t] mismatch at word %0d: %s", $time, words_seen, msg);
			errors++;
		endtask

		task compare(string name, logic [kct_pkg::AMT_W-1:0] got,
				logic [kct_pkg::AMT_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
		endtask

		// Check one accepted result word against the oldest expectation.
		task check_result(logic [kct_pkg::DATA_W-1:0] word, logic tlast);
			table_result_t want;
			words_seen++;
			if (due_q.size() == 0) begin
				report($sformatf("unexpected word 0x%0h", word));
				return;
			end
			want = due_q.pop_front();
			compare("status", kct_pkg::AMT_W'(word[2:0]), kct_pkg::AMT_W'(want.status));
			compare("slot", kct_pkg::AMT_W'(word[8:3]), kct_pkg::AMT_W'(want.slot));
			compare("entry_key", kct_pkg::AMT_W'(word[24:9]), kct_pkg::AMT_W'(want.key));
			compare("entry_amount", word[56:25], want.amount);
			compare("entries_used", kct_pkg::AMT_W'(word[62:57]), kct_pkg::AMT_W'(want.used));
			compare("tlast", kct_pkg::AMT_W'(tlast), kct_pkg::AMT_W'(want.last));
		endtask
	endclass

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       psel     = 1'b0;
	logic                       penable  = 1'b0;
	logic                       pwrite   = 1'b0;
	logic [2:0]                 paddr    = '0;
	logic [31:0]                pwdata   = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [kct_pkg::DATA_W-1:0] s_tdata  = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [kct_pkg::DATA_W-1:0] m_tdata;
	logic                       m_tlast;

	count_table_model sb = new();

	int burst_left  = 0;
	int hold_cycles = 0;
	int cycle_count = 0;

	keyed_count_table_core #(.SLOTS(SLOTS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Check every result word taken from the block.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
	end

	// Receiver: runs of ready broken by short stalls; a long hold-off wins over both.
	initial begin
		int rx_run;
		int rx_stall;
		rx_run   = 0;
		rx_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (rx_run > 0) begin
				m_tready <= 1'b1;
				rx_run--;
			end else if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else begin
				// pick the next pattern; leave ready as it is this cycle
				rx_run   = $urandom_range(1, 24);
				rx_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
			end
		end
	end

	function automatic command_t make_command(logic [kct_pkg::OPC_W-1:0] op,
			logic [kct_pkg::KEY_W-1:0] key, logic [kct_pkg::AMT_W-1:0] amount,
			logic [kct_pkg::SIDX_W-1:0] sidx);
		command_t c;
		c.op     = op;
		c.key    = key;
		c.amount = amount;
		c.sidx   = sidx;
		return c;
	endfunction

	// Random command, biased toward keys from a small pool and amounts that
	// match live counts, so that exact removes and amount matches are frequent.
	function automatic command_t random_command(logic [kct_pkg::KEY_W-1:0] key_base, int pool,
			logic [kct_pkg::AMT_W-1:0] amt_hi);
		command_t c;
		int pick;
		int mode;
		int live;
		pick = $urandom_range(0, 99);
		if (pick < 34)
			c.op = kct_pkg::OP_ADD;
		else if (pick < 56)
			c.op = kct_pkg::OP_REMOVE;
		else if (pick < 66)
			c.op = kct_pkg::OP_FIND_KEY;
		else if (pick < 76)
			c.op = kct_pkg::OP_READ_SLOT;
		else if (pick < 94)
			c.op = kct_pkg::OP_FIND_AMOUNT;
		else
			c.op = kct_pkg::OPC_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		c.key  = ($urandom_range(0, 6) == 0) ? kct_pkg::KEY_W'($urandom)
		                                     : key_base + kct_pkg::KEY_W'($urandom_range(0, pool - 1));
		c.sidx = ($urandom_range(0, 3) == 0) ? kct_pkg::SIDX_W'($urandom)
		                                     : kct_pkg::SIDX_W'($urandom_range(0, sb.used + 1));
		mode   = $urandom_range(0, 19);
		if (mode == 0) begin
			c.amount = '0;
		end else if (mode <= 7 && sb.used > 0) begin
			live     = $urandom_range(0, sb.used - 1);
			c.amount = sb.counts[live];
			// aim most of these removes at the entry itself
			if (c.op == kct_pkg::OP_REMOVE && mode <= 5)
				c.key = sb.keys[live];
		end else if (mode <= 13) begin
			c.amount = $urandom_range(1, amt_hi);
		end else if (mode <= 16) begin
			c.amount = $urandom;
		end else begin
			c.amount = sb.limit - $urandom_range(0, 2);
		end
		return c;
	endfunction

	// Offer one command word and hold it until taken; idle in bursts.
	task automatic offer_word(command_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tdata  <= {7'b0, c.sidx, c.amount, c.key, c.op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_command(c);
	endtask

	// Drop valid and wait until every owed word has come back.
	task automatic drain_results();
		s_tvalid  <= 1'b0;
		burst_left = 0;
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write count_limit through the APB port, then read it back.
	task automatic write_limit(logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.limit = value;
		// read back straight after the write
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== value)
			sb.report($sformatf("count_limit read 0x%0h want 0x%0h", prdata, value));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic random_phase(logic [kct_pkg::KEY_W-1:0] key_base, int pool,
			logic [kct_pkg::AMT_W-1:0] amt_hi, int count);
		for (int n = 0; n < count; n++)
			offer_word(random_command(key_base, pool, amt_hi));
	endtask

	initial begin
		logic [kct_pkg::KEY_W-1:0] fill_base;
		logic [kct_pkg::AMT_W-1:0] limit_mid;
		int n;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed pass at the reset limit (all ones).
		// Zero amount is flagged for add, remove and find amount.
		offer_word(make_command(kct_pkg::OP_ADD, 16'h0001, '0, '0));
		offer_word(make_command(kct_pkg::OP_REMOVE, 16'h0001, '0, '0));
		offer_word(make_command(kct_pkg::OP_FIND_AMOUNT, 16'h0001, '0, '0));
		// Empty table: unknown key, slot out of range.
		offer_word(make_command(kct_pkg::OP_FIND_KEY, 16'h1234, 32'd1, '0));
		offer_word(make_command(kct_pkg::OP_REMOVE, 16'h1234, 32'd1, '0));
		offer_word(make_command(kct_pkg::OP_READ_SLOT, '0, 32'd1, 6'd0));
		// Most negative key with the largest count, then push it over the limit.
		offer_word(make_command(kct_pkg::OP_ADD, 16'h8000, 32'hFFFF_FFFF, '0));
		offer_word(make_command(kct_pkg::OP_ADD, 16'h8000, 32'd1, '0));
		offer_word(make_command(kct_pkg::OP_ADD, 16'h7FFF, 32'd5, '0));
		offer_word(make_command(kct_pkg::OP_ADD, 16'h7FFF, 32'd3, '0));
		offer_word(make_command(kct_pkg::OP_ADD, 16'h0000, 32'd8, '0));
		// Two amount matches, then none.
		offer_word(make_command(kct_pkg::OP_FIND_AMOUNT, '0, 32'd8, '0));
		offer_word(make_command(kct_pkg::OP_FIND_AMOUNT, '0, 32'd12345, '0));
		offer_word(make_command(kct_pkg::OP_READ_SLOT, '0, 32'd1, 6'd1));
		offer_word(make_command(kct_pkg::OP_READ_SLOT, '0, 32'd1, 6'd3));
		offer_word(make_command(kct_pkg::OP_READ_SLOT, '0, 32'd1, 6'd4));
		offer_word(make_command(kct_pkg::OP_READ_SLOT, '0, 32'd1, 6'd63));
		// Remove too much, then partly, then exactly (middle entry shifts down).
		offer_word(make_command(kct_pkg::OP_REMOVE, 16'h7FFF, 32'd9, '0));
		offer_word(make_command(kct_pkg::OP_REMOVE, 16'h7FFF, 32'd3, '0));
		offer_word(make_command(kct_pkg::OP_REMOVE, 16'h7FFF, 32'd5, '0));
		offer_word(make_command(kct_pkg::OP_FIND_KEY, 16'h0000, 32'd1, '0));
		offer_word(make_command(kct_pkg::OP_READ_SLOT, '0, 32'd1, 6'd2));
		// Undefined opcodes.
		offer_word(make_command(OP_SPARE_FIRST, 16'h0000, 32'd1, 6'd1));
		offer_word(make_command(OP_SPARE_FIRST + 3'd1, 16'hFFFF, 32'hFFFF_FFFF, 6'd63));
		offer_word(make_command(OP_SPARE_LAST, 16'h8000, 32'd8, 6'd2));
		drain_results();

		// Smallest limit: almost every add overflows, new keys only with amount 1.
		write_limit(32'd1);
		random_phase(kct_pkg::KEY_W'($urandom), 6, 32'd2, 60);
		drain_results();

		// Moderate limit: fill the table with equal counts, overflow it, and
		// list all of them while the receiver holds off.
		write_limit(32'd1000);
		fill_base = kct_pkg::KEY_W'($urandom);
		n = 0;
		while (sb.used < SLOTS) begin
			offer_word(make_command(kct_pkg::OP_ADD, fill_base + kct_pkg::KEY_W'(n), 32'd7, '0));
			n++;
		end
		offer_word(make_command(kct_pkg::OP_ADD, fill_base + kct_pkg::KEY_W'(n), 32'd7, '0));
		offer_word(make_command(kct_pkg::OP_ADD, fill_base + kct_pkg::KEY_W'(n + 1), 32'd1000,
			'0));
		// long hold-off: keep offering so the block backs up onto its input
		hold_cycles = 400;
		offer_word(make_command(kct_pkg::OP_FIND_AMOUNT, '0, 32'd7, '0));
		random_phase(fill_base, SLOTS + 4, 32'd300, 100);
		drain_results();

		// Random mid-range limit, with a full drain partway through.
		limit_mid = $urandom_range(2, 32'hFFFF_FFFE);
		write_limit(limit_mid);
		random_phase(kct_pkg::KEY_W'($urandom), 10, limit_mid / 4 + 1, 40);
		drain_results();
		random_phase(kct_pkg::KEY_W'($urandom), 10, limit_mid / 4 + 1, 40);
		drain_results();

		// Largest limit with amounts across the full range.
		write_limit(32'hFFFF_FFFF);
		random_phase(kct_pkg::KEY_W'($urandom), 12, 32'hFFFF_FFFF, 80);

		// Wait for every owed word, then let the block settle.
		s_tvalid <= 1'b0;
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (sb.errors == 0 && sb.due_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
